// ===== rtl/core/bsep_pkg.sv =====
`timescale 1ns / 1ps
package bsep_pkg;

  localparam int MAX_ITER_LIMIT    = 256;
  localparam int COLOUR_TABLE_SIZE = 1024;
  localparam int FRACTION_BITS     = 28;

  localparam int ITER_W  = $clog2(MAX_ITER_LIMIT);
  localparam int LIM_W   = 9;
  localparam int COL_W   = 12;
  localparam int IDX_W   = $clog2(COLOUR_TABLE_SIZE);
  localparam int ZW      = 34;
  localparam int MUL_W   = 32;
  localparam int CW_FULL = 45;
  localparam int MAG_SH  = 2 * FRACTION_BITS - IDX_W;
  localparam int MAG_W   = 64 - MAG_SH + 1;
  localparam int ROOT_STEPS = (MAG_W + 1) / 2;
  localparam int ESC_BIT = 2 * FRACTION_BITS + 2;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_ORIGIN_RE = 2'd0;
  localparam logic [1:0] REG_ORIGIN_IM = 2'd1;
  localparam logic [1:0] REG_STEP      = 2'd2;
  localparam logic [1:0] REG_MAX_ITER  = 2'd3;

  localparam logic signed [31:0] ORIGIN_RE_RST = -32'sd603979776;
  localparam logic signed [31:0] ORIGIN_IM_RST = -32'sd603979776;
  localparam logic [30:0]        STEP_RST      = 31'd1174405;
  localparam logic [LIM_W-1:0]   MAX_ITER_RST  = 9'd200;

  typedef struct packed {
    logic              valid;
    logic              done;
    logic [ITER_W-1:0] esc_i;
    logic [MAG_W-1:0]  mag;
  } bsep_tag_t;

  typedef struct packed {
    logic signed [ZW-1:0] re;
    logic signed [ZW-1:0] im;
  } bsep_cplx_t;

  typedef struct packed {
    logic             valid;
    logic             in_set;
    logic [IDX_W-1:0] idx;
  } bsep_pix_t;

  typedef logic [23:0] bsep_rom_t [COLOUR_TABLE_SIZE];

  // Q30 colour math constants
  localparam int CQ = 30;
  localparam longint ONE_Q   = longint'(1) <<< CQ;
  localparam longint Q96     = (longint'(96) <<< CQ) / 116;
  localparam longint Q549    = (longint'(549) <<< CQ) / 1000;
  localparam longint Q578    = (longint'(578) <<< CQ) / 1000;
  localparam longint Q629    = (longint'(629) <<< CQ) / 1000;
  localparam longint Q324    = (longint'(324) <<< CQ) / 100;
  localparam longint Q154    = (longint'(154) <<< CQ) / 100;
  localparam longint Q499    = (longint'(499) <<< CQ) / 1000;
  localparam longint Q969    = (longint'(969) <<< CQ) / 1000;
  localparam longint Q188    = (longint'(188) <<< CQ) / 100;
  localparam longint Q415    = (longint'(415) <<< CQ) / 10000;
  localparam longint Q557    = (longint'(557) <<< CQ) / 10000;
  localparam longint Q204    = (longint'(204) <<< CQ) / 1000;
  localparam longint Q1057   = (longint'(1057) <<< CQ) / 1000;
  localparam longint Q31308  = (longint'(31308) <<< CQ) / 10000000;
  localparam longint Q1292   = (longint'(1292) <<< CQ) / 100;
  localparam longint Q1055   = (longint'(1055) <<< CQ) / 1000;
  localparam longint Q55     = (longint'(55) <<< CQ) / 1000;
  localparam longint unsigned CH_DEN = longint'(10) <<< CQ;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam longint unsigned SIN_DIV [1:10] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};
  localparam longint unsigned COS_DIV [1:10] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

  function automatic longint unsigned bsep_isqrt(longint unsigned x);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = x;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned bsep_cube(longint unsigned r);
    return (((r * r) >> CQ) * r) >> CQ;
  endfunction

  function automatic longint unsigned bsep_cbrt(longint unsigned w);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = (64'd1 << 31) - 1;
    for (int j = 0; j < 40; j++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        if (bsep_cube(mid) <= w) lo = mid;
        else hi = mid - 1;
      end
    end
    return lo;
  endfunction

  function automatic logic [7:0] bsep_channel(longint vin);
    longint v;
    longint o;
    longint unsigned s, q4, q6, y, num, q, rem;
    v = vin;
    if (v < 0) v = 0;
    if (v > ONE_Q) v = ONE_Q;
    if (v < Q31308) begin
      o = (Q1292 * v) >>> CQ;
    end else begin
      s  = bsep_isqrt(64'(v) << CQ);
      q4 = bsep_isqrt(s << CQ);
      q6 = bsep_cbrt(s);
      y  = (q4 * q6) >> CQ;
      o  = ((Q1055 * longint'(y)) >>> CQ) - Q55;
      if (o < 0) o = 0;
    end
    num = 64'(o) * 64'd2554;
    q   = num / CH_DEN;
    rem = num - q * CH_DEN;
    if (2 * rem > CH_DEN || (2 * rem == CH_DEN && q[0])) q = q + 1;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [23:0] bsep_colour(int unsigned k);
    longint unsigned phi, p2, ts, tc;
    longint ss, sc, co, si, fx, fz, x, y, z, r, g, b;
    logic [1:0] quad;
    quad = 2'(k >> 8);
    phi = (64'(k & 255) * PI_Q30 * 64'd2) >> IDX_W;
    p2  = (phi * phi) >> CQ;
    ts  = phi;
    tc  = 64'(ONE_Q);
    ss  = longint'(phi);
    sc  = ONE_Q;
    for (int n = 1; n <= 10; n++) begin
      ts = ((ts * p2) >> CQ) / SIN_DIV[n];
      tc = ((tc * p2) >> CQ) / COS_DIV[n];
      if (n % 2 == 1) begin
        ss = ss - longint'(ts);
        sc = sc - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        sc = sc + longint'(tc);
      end
    end
    case (quad)
      2'd0:    begin co = sc;  si = ss;  end
      2'd1:    begin co = -ss; si = sc;  end
      2'd2:    begin co = -sc; si = -ss; end
      default: begin co = ss;  si = -sc; end
    endcase
    fx = Q96 + co / 5;
    fz = Q96 - si / 2;
    x = (Q549 * longint'(bsep_cube(64'(fx)))) >>> CQ;
    y = (Q578 * longint'(bsep_cube(64'(Q96)))) >>> CQ;
    z = (Q629 * longint'(bsep_cube(64'(fz)))) >>> CQ;
    r = (Q324 * x - Q154 * y - Q499 * z) >>> CQ;
    g = (-Q969 * x + Q188 * y + Q415 * z) >>> CQ;
    b = (Q557 * x - Q204 * y + Q1057 * z) >>> CQ;
    return {bsep_channel(r), bsep_channel(g), bsep_channel(b)};
  endfunction

  function automatic bsep_rom_t bsep_build_rom();
    bsep_rom_t t;
    for (int k = 0; k < COLOUR_TABLE_SIZE; k++) begin
      t[k] = bsep_colour(k);
    end
    return t;
  endfunction

  localparam bsep_rom_t COLOUR_ROM = bsep_build_rom();

endpackage

// ===== rtl/core/burning_ship_escape_time_pixel.sv =====
`timescale 1ns / 1ps
// Burning Ship escape-time pixel colouring. Each transfer carries a pixel column and row;
// the point origin + index * pixel_step runs through a chain of 256 iteration cells, one
// cell per iteration and two register stages per cell, then a 10-stage ceiling square root
// and the registered colour lookup. A new pixel is taken every clock unless the chain stalls;
// each pixel's result passes through 525 register stages and is presented in input order.
// The chain stalls only when a finished result meets a stalled output register.
// Registers: 0 origin_re, 1 origin_im, 2 pixel_step, 3 max_iterations (byte address 4*n).
module burning_ship_escape_time_pixel import bsep_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [COL_W-1:0]    column_i,
  input  logic [COL_W-1:0]    row_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic                inside_set_o,
  output logic [IDX_W-1:0]    colour_index_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic signed [31:0] origin_re_q, origin_im_q;
  logic [30:0]        step_q;
  logic [LIM_W-1:0]   max_iter_q, limit;
  logic               en, out_ld, take;
  logic [1:0]         reg_sel;

  bsep_tag_t  tag_w  [MAX_ITER_LIMIT+1];
  bsep_cplx_t z_w    [MAX_ITER_LIMIT+1];
  bsep_cplx_t c_w    [MAX_ITER_LIMIT+1];
  logic       huge_w [MAX_ITER_LIMIT+1];
  logic       entry_valid;
  bsep_pix_t  pix;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_re_q <= ORIGIN_RE_RST;
      origin_im_q <= ORIGIN_IM_RST;
      step_q      <= STEP_RST;
      max_iter_q  <= MAX_ITER_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_ORIGIN_RE: origin_re_q <= pwdata;
        REG_ORIGIN_IM: origin_im_q <= pwdata;
        REG_STEP:      step_q      <= pwdata[30:0];
        REG_MAX_ITER:  max_iter_q  <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ORIGIN_RE: prdata = origin_re_q;
      REG_ORIGIN_IM: prdata = origin_im_q;
      REG_STEP:      prdata = {1'b0, step_q};
      REG_MAX_ITER:  prdata = 32'(max_iter_q);
      default:       prdata = '0;
    endcase
  end

  assign limit = (max_iter_q > LIM_W'(MAX_ITER_LIMIT)) ? LIM_W'(MAX_ITER_LIMIT) : max_iter_q;

  // the whole chain shifts unless a finished pixel would overrun a held result
  assign out_ld     = !out_valid_o || !out_stall_i;
  assign en         = out_ld || !pix.valid;
  assign in_stall_o = !en;
  assign take       = in_valid_i && en;

  bsep_entry u_entry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .take_i      (take),
    .column_i    (column_i),
    .row_i       (row_i),
    .origin_re_i (origin_re_q),
    .origin_im_i (origin_im_q),
    .step_i      (step_q),
    .valid_o     (entry_valid),
    .c_o         (c_w[0]),
    .huge_o      (huge_w[0])
  );

  // z after the first step is c itself
  assign z_w[0]         = c_w[0];
  assign tag_w[0].valid = entry_valid;
  assign tag_w[0].done  = 1'b0;
  assign tag_w[0].esc_i = '0;
  assign tag_w[0].mag   = '0;

  for (genvar k = 0; k < MAX_ITER_LIMIT; k++) begin : g_cell
    bsep_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .limit_i (limit),
      .iter_i  (ITER_W'(k)),
      .tag_i   (tag_w[k]),
      .z_i     (z_w[k]),
      .c_i     (c_w[k]),
      .huge_i  (huge_w[k]),
      .tag_o   (tag_w[k+1]),
      .z_o     (z_w[k+1]),
      .c_o     (c_w[k+1]),
      .huge_o  (huge_w[k+1])
    );
  end

  bsep_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_w[MAX_ITER_LIMIT]),
    .pix_o  (pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ld) begin
      out_valid_o <= pix.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld && pix.valid) begin
      inside_set_o <= pix.in_set;
      if (pix.in_set) begin
        {red_o, green_o, blue_o} <= '0;
        colour_index_o           <= '0;
      end else begin
        {red_o, green_o, blue_o} <= COLOUR_ROM[pix.idx];
        colour_index_o           <= pix.idx;
      end
    end
  end

endmodule

// ===== rtl/core/bsep_entry.sv =====
`timescale 1ns / 1ps
module bsep_entry import bsep_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              take_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic [COL_W-1:0]  row_i,
  input  logic signed [31:0] origin_re_i,
  input  logic signed [31:0] origin_im_i,
  input  logic [30:0]       step_i,
  output logic              valid_o,
  output bsep_cplx_t        c_o,
  output logic              huge_o
);

  localparam int PW = COL_W + 31;

  logic          v1_q;
  logic [PW-1:0] pre_q, pim_q;
  logic signed [CW_FULL-1:0] cre_d, cim_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= take_i;
      valid_o <= v1_q;
    end
  end

  assign cre_d = CW_FULL'(origin_re_i) + $signed(CW_FULL'(pre_q));
  assign cim_d = CW_FULL'(origin_im_i) + $signed(CW_FULL'(pim_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q   <= PW'(column_i) * PW'(step_i);
      pim_q   <= PW'(row_i) * PW'(step_i);
      c_o.re  <= cre_d[ZW-1:0];
      c_o.im  <= cim_d[ZW-1:0];
      // point far outside the coordinate range: escapes on the first step
      huge_o  <= (cre_d[CW_FULL-1:ZW-1] != '0 && cre_d[CW_FULL-1:ZW-1] != '1) ||
                 (cim_d[CW_FULL-1:ZW-1] != '0 && cim_d[CW_FULL-1:ZW-1] != '1);
    end
  end

endmodule

// ===== rtl/core/bsep_cell.sv =====
`timescale 1ns / 1ps
module bsep_cell import bsep_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [LIM_W-1:0]  limit_i,
  input  logic [ITER_W-1:0] iter_i,
  input  bsep_tag_t         tag_i,
  input  bsep_cplx_t        z_i,
  input  bsep_cplx_t        c_i,
  input  logic              huge_i,
  output bsep_tag_t         tag_o,
  output bsep_cplx_t        z_o,
  output bsep_cplx_t        c_o,
  output logic              huge_o
);

  logic [ZW-1:0] ar, ai;
  logic [63:0]   a2_q, b2_q, p_q;
  logic          sat_q, huge_q;
  bsep_cplx_t    c_q;
  bsep_tag_t     tag_q, tag_d;
  logic [64:0]   sum;
  logic [63:0]   d2;
  logic          esc;
  logic [MAG_W-1:0] mag;
  logic signed [64:0] diff, diff_sh;

  assign ar = z_i.re[ZW-1] ? ZW'(-z_i.re) : ZW'(z_i.re);
  assign ai = z_i.im[ZW-1] ? ZW'(-z_i.im) : ZW'(z_i.im);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q   <= 64'(ar[MUL_W-1:0]) * 64'(ar[MUL_W-1:0]);
      b2_q   <= 64'(ai[MUL_W-1:0]) * 64'(ai[MUL_W-1:0]);
      p_q    <= 64'(ar[MUL_W-1:0]) * 64'(ai[MUL_W-1:0]);
      sat_q  <= huge_i || (ar[ZW-1:MUL_W] != '0) || (ai[ZW-1:MUL_W] != '0);
      c_q    <= c_i;
      huge_q <= huge_i;
    end
  end

  // |z|^2 of the incoming point, saturating
  assign sum = {1'b0, a2_q} + {1'b0, b2_q};
  assign d2  = (sat_q || sum[64]) ? '1 : sum[63:0];
  assign esc = d2 > (64'd1 << ESC_BIT);
  assign mag = MAG_W'(d2 >> MAG_SH) + MAG_W'(d2[MAG_SH-1:0] != '0);

  assign diff    = $signed({1'b0, a2_q}) - $signed({1'b0, b2_q});
  assign diff_sh = diff >>> FRACTION_BITS;

  always_comb begin
    tag_d = tag_q;
    if (tag_q.valid && !tag_q.done && ({1'b0, iter_i} < limit_i) && esc) begin
      tag_d.done  = 1'b1;
      tag_d.esc_i = iter_i;
      tag_d.mag   = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
      tag_o <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
      tag_o <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_o.re <= diff_sh[ZW-1:0] + c_q.re;
      z_o.im <= p_q[ZW+FRACTION_BITS-2:FRACTION_BITS-1] + c_q.im;
      c_o    <= c_q;
      huge_o <= huge_q;
    end
  end

endmodule

// ===== rtl/core/bsep_root.sv =====
`timescale 1ns / 1ps
module bsep_root import bsep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  bsep_tag_t tag_i,
  output bsep_pix_t pix_o
);

  // one result bit per stage, then round up to a ceiling root
  logic [MAG_W-1:0] x_q [ROOT_STEPS];
  logic [MAG_W-1:0] r_q [ROOT_STEPS];
  bsep_tag_t        t_q [ROOT_STEPS];
  logic [IDX_W-1:0] n;

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam logic [MAG_W-1:0] BIT = MAG_W'(1) << (2 * (ROOT_STEPS - 1 - j));
    logic [MAG_W-1:0] x_in, r_in, x_d, r_d;
    bsep_tag_t        t_in;

    if (j == 0) begin : g_first
      assign x_in = tag_i.mag;
      assign r_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign x_in = x_q[j-1];
      assign r_in = r_q[j-1];
      assign t_in = t_q[j-1];
    end

    always_comb begin
      if (x_in >= r_in + BIT) begin
        x_d = x_in - (r_in + BIT);
        r_d = (r_in >> 1) + BIT;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        t_q[j] <= '0;
      end else if (en_i) begin
        t_q[j] <= t_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j] <= x_d;
        r_q[j] <= r_d;
      end
    end
  end

  assign n = r_q[ROOT_STEPS-1][IDX_W-1:0] + IDX_W'(x_q[ROOT_STEPS-1] != '0);

  assign pix_o.valid  = t_q[ROOT_STEPS-1].valid;
  assign pix_o.in_set = !t_q[ROOT_STEPS-1].done;
  assign pix_o.idx    = IDX_W'({t_q[ROOT_STEPS-1].esc_i, 7'b0}) - n;

endmodule

// ===== rtl/core/bsep_checker.sv =====
`timescale 1ns / 1ps
module bsep_checker import bsep_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [COL_W-1:0] column_i,
  input logic [COL_W-1:0] row_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [7:0]       red_o,
  input logic [7:0]       green_o,
  input logic [7:0]       blue_o,
  input logic             inside_set_o,
  input logic [IDX_W-1:0] colour_index_o,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             pready
);

  logic [11:0] pending_q;
  logic        in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pending_q <= '0;
    else pending_q <= pending_q + 12'(in_xfer) - 12'(out_xfer);
  end

  a_inside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_set_o) |->
      (red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0 && colour_index_o == '0))
    else $error("inside pixel is not black");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != '0)
    else $error("result without a pixel");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(colour_index_o) && $stable(inside_set_o) &&
       $stable(red_o) && $stable(green_o) && $stable(blue_o)))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind burning_ship_escape_time_pixel bsep_checker u_bsep_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import bsep_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 600;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             in_set;
    logic [IDX_W-1:0] idx;
  } pix_t;

  // Escape-time predictor with its own colour table and register copy
  class pixel_board;
    longint          org_re;
    longint          org_im;
    longint unsigned step;
    int unsigned     iter_reg;
    logic [23:0]     hue[COLOUR_TABLE_SIZE];
    pix_t            pending[$];
    int              errors;

    function new();
      org_re   = -603979776;
      org_im   = -603979776;
      step     = 1174405;
      iter_reg = 200;
      errors   = 0;
      for (int k = 0; k < COLOUR_TABLE_SIZE; k++) hue[k] = hue_entry(k);
    endfunction

    function longint qc(longint n, longint d);
      return (n <<< 30) / d;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned cubed(longint unsigned r);
      return (((r * r) >> 30) * r) >> 30;
    endfunction

    function longint unsigned cube_root(longint unsigned w);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = (64'd1 << 31) - 1;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        if (cubed(mid) <= w) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    // linear light to 8-bit sRGB code
    function logic [7:0] gamma_code(longint v);
      longint o;
      longint unsigned s, q4, q6, y, num, den, q, rem;
      if (v < 0) v = 0;
      if (v > (longint'(1) <<< 30)) v = longint'(1) <<< 30;
      if (v < qc(31308, 10000000)) begin
        o = (qc(1292, 100) * v) >>> 30;
      end else begin
        s  = root_floor(64'(v) << 30);
        q4 = root_floor(s << 30);
        q6 = cube_root(s);
        y  = (q4 * q6) >> 30;
        o  = ((qc(1055, 1000) * longint'(y)) >>> 30) - qc(55, 1000);
        if (o < 0) o = 0;
      end
      num = 64'(o) * 64'd2554;
      den = 64'd10 << 30;
      q   = num / den;
      rem = num - q * den;
      if (2 * rem > den || (2 * rem == den && q[0])) q = q + 1;
      return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function logic [23:0] hue_entry(int unsigned ix);
      longint unsigned phi, p2, ts, tc;
      longint ss, sc, co, si, fx, fz, x, y, z, r, g, b;
      int unsigned quad, n;
      quad = (ix / 256) & 3;
      phi = (64'(ix % 256) * 64'd3373259426 * 64'd2) / 64'd1024;
      p2  = (phi * phi) >> 30;
      ts  = phi;
      tc  = 64'd1 << 30;
      ss  = longint'(phi);
      sc  = longint'(1) <<< 30;
      for (n = 1; n <= 10; n++) begin
        ts = ((ts * p2) >> 30) / 64'((2 * n) * (2 * n + 1));
        tc = ((tc * p2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          ss = ss - longint'(ts);
          sc = sc - longint'(tc);
        end else begin
          ss = ss + longint'(ts);
          sc = sc + longint'(tc);
        end
      end
      case (quad)
        0: begin co = sc;  si = ss;  end
        1: begin co = -ss; si = sc;  end
        2: begin co = -sc; si = -ss; end
        default: begin co = ss; si = -sc; end
      endcase
      fx = qc(96, 116) + co / 5;
      fz = qc(96, 116) - si / 2;
      x = (qc(549, 1000) * longint'(cubed(64'(fx)))) >>> 30;
      y = (qc(578, 1000) * longint'(cubed(64'(qc(96, 116))))) >>> 30;
      z = (qc(629, 1000) * longint'(cubed(64'(fz)))) >>> 30;
      r = (qc(324, 100) * x - qc(154, 100) * y - qc(499, 1000) * z) >>> 30;
      g = (-qc(969, 1000) * x + qc(188, 100) * y + qc(415, 10000) * z) >>> 30;
      b = (qc(557, 10000) * x - qc(204, 1000) * y + qc(1057, 1000) * z) >>> 30;
      return {gamma_code(r), gamma_code(g), gamma_code(b)};
    endfunction

    function void set_reg(logic [1:0] sel, logic [31:0] d);
      case (sel)
        REG_ORIGIN_RE: org_re = longint'(signed'(d));
        REG_ORIGIN_IM: org_im = longint'(signed'(d));
        REG_STEP:      step = 64'(d[30:0]);
        default:       iter_reg = d[8:0];
      endcase
    endfunction

    function pix_t escape_colour(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
      longint cr, ci, zr, zi;
      longint unsigned ar, ai, a2, b2, d2, m, n;
      int unsigned cap;
      logic [31:0] val;
      pix_t p;
      cr = org_re + longint'(64'(col) * step);
      ci = org_im + longint'(64'(row) * step);
      zr = 0;
      zi = 0;
      cap = (iter_reg > MAX_ITER_LIMIT) ? MAX_ITER_LIMIT : iter_reg;
      p = '0;
      p.in_set = 1'b1;
      for (int unsigned i = 0; i < cap; i++) begin
        ar = (zr < 0) ? -zr : zr;
        ai = (zi < 0) ? -zi : zi;
        zr = ((longint'(ar * ar) - longint'(ai * ai)) >>> FRACTION_BITS) + cr;
        zi = longint'((ar * ai) >> (FRACTION_BITS - 1)) + ci;
        ar = (zr < 0) ? -zr : zr;
        ai = (zi < 0) ? -zi : zi;
        if ((ar >> 32) != 0 || (ai >> 32) != 0) begin
          d2 = '1;
        end else begin
          a2 = ar * ar;
          b2 = ai * ai;
          d2 = (a2 > ~b2) ? '1 : a2 + b2;
        end
        if (d2 > (64'd4 << (2 * FRACTION_BITS))) begin
          m = (d2 >> MAG_SH) + 64'((d2 & ((64'd1 << MAG_SH) - 1)) != 0);
          n = root_floor(m);
          if (n * n < m) n = n + 1;
          val = 32'd65536 + 32'd128 * i - 32'(n);
          p.idx = val[IDX_W-1:0];
          {p.red, p.green, p.blue} = hue[p.idx];
          p.in_set = 1'b0;
          break;
        end
      end
      return p;
    endfunction

    function void note_pixel(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
      pending.push_back(escape_colour(col, row));
    endfunction

    function void check_result(pix_t got);
      pix_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: rgb exp %h_%h_%h got %h_%h_%h, inside exp %b got %b, ",
                    "idx exp %0d got %0d"},
                   want.red, want.green, want.blue, got.red, got.green, got.blue,
                   want.in_set, got.in_set, want.idx, got.idx);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [COL_W-1:0]  column_i = '0;
  logic [COL_W-1:0]  row_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        red_o, green_o, blue_o;
  logic              inside_set_o;
  logic [IDX_W-1:0]  colour_index_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  pixel_board board;
  int idle_in  = 34;
  int idle_out = 84;
  int cycles   = 0;

  burning_ship_escape_time_pixel dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output side: random stall, check each transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result({red_o, green_o, blue_o, inside_set_o, colour_index_o});
    out_stall_i <= ($urandom_range(99) < idle_out);
  end

  task automatic write_reg(logic [1:0] sel, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(sel, d);
  endtask

  task automatic send_pixel(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
    while ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    column_i   <= col;
    row_i      <= row;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pixel(col, row);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] re, logic [31:0] im, logic [31:0] st,
                           logic [31:0] lim);
    drain();
    write_reg(REG_ORIGIN_RE, re);
    write_reg(REG_ORIGIN_IM, im);
    write_reg(REG_STEP, st);
    write_reg(REG_MAX_ITER, lim);
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset view: corners, middle and alternating bit patterns
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    send_pixel(12'd1900, 12'd1700);
    // zero limit: everything inside
    write_all(32'hf000_0000, 32'h1000_0000, 32'h7fff_ffff, 32'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    // points next to zero at the full limit and with the limit over range
    write_all(32'd0, 32'hffff_ff00, 32'd1, 32'd256);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    write_all(32'd0, 32'd0, 32'd3, 32'h0000_01ff);
    send_pixel(12'd17, 12'd4000);
    send_pixel(12'd0, 12'd0);
    // huge and large points, some saturating the magnitude, at iteration limits of one and two
    write_all(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    write_all(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd2);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd1);

    for (int ph = 0; ph < 3; ph++) begin
      idle_in  = (ph == 0) ? 34 : (ph == 1) ? 84 : 0;
      idle_out = (ph == 0) ? 84 : (ph == 1) ? 34 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        if (blk == 3) begin
          // raw register noise
          write_all($urandom, $urandom, $urandom, $urandom);
        end else begin
          write_all(-32'sd671088640 + $urandom_range(268435456),
                    -32'sd590558003 + $urandom_range(268435456),
                    $urandom_range(262144, 49152),
                    ($urandom_range(9) == 0) ? $urandom_range(511, 257)
                                             : $urandom_range(256, 1));
        end
        repeat (108) send_pixel($urandom, $urandom);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
